@@ hdl/lru_key_value_cache_core_defines.svh @@
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define LRUC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lru cache assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define LRUC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru cache assertion failed");

`else

`define LRUC_ASSERT(label, clk, rst_n, prop)
`define LRUC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/lruc_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Command codes, item payload types and fixed constants of the cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lruc_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 5;

  localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
  localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [VALUE_W-1:0] PUT_VALUE  = 32'h0000_0000;

  typedef enum logic [0:0] {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                       command;
    logic signed [KEY_W-1:0]    key;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                       hit;
    logic signed [VALUE_W-1:0]  read_value;
  } rsp_t;

endpackage

@@ hdl/lruc_stream_if.sv @@
// ----------------------------------------------------------------------------
// LRU cache stream interface
// Valid/ready channel carrying one item payload from source to sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lruc_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

@@ hdl/lru_key_value_cache_core.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Fully associative key/value cache with least-recently-used replacement.
//
// Requests enter on req_i (command, key, value) and results leave on rsp_o
// (hit, read_value); both are valid/ready channels and an item moves when
// valid and ready are high at a rising edge of clk_i. The capacity register
// is written through cfg_we_i / cfg_wdata_i; the user must do so only while
// the cache is idle, as the block itself does not enforce it. Each item is
// registered, looked up and applied to the store in one pass through the
// entry compare and rank update, and its result lands in the output
// register, from which rsp_o.valid rises. One item is accepted every cycle
// while the output register is free, bounded by the combinational compare
// across all entries and the rank update that follows it.
// When the receiver holds rsp_o.ready low, the result stays in the output
// register, one more item waits in the input register, and req_i.ready
// drops until the result is taken. Reset clears all entries at once and
// loads a capacity of 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_defines.svh"

module lru_key_value_cache_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lruc_pkg::CAP_W-1:0]   cfg_wdata_i,
  lruc_stream_if.sink                  req_i,
  lruc_stream_if.source                rsp_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic            s1_valid_q, s1_valid_d;
  lruc_pkg::req_t  s1_req_q;
  logic            s2_valid_q, s2_valid_d;
  lruc_pkg::rsp_t  s2_rsp_q;
  lruc_pkg::rsp_t  store_rsp;
  logic            s2_free, s1_fire, in_fire;
  logic [ENTRIES-1:0] entry_valid;
  logic [CntW-1:0]    entry_count;
  logic                    get_fire;
  logic [ENTRIES+CntW-1:0] entry_state;

  assign s2_free = !s2_valid_q || rsp_o.ready;
  assign s1_fire = s1_valid_q && s2_free;
  assign in_fire = req_i.valid && req_i.ready;

  assign req_i.ready   = !s1_valid_q || s2_free;
  assign rsp_o.valid   = s2_valid_q;
  assign rsp_o.payload = s2_rsp_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s1_fire) begin
      s2_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q <= req_i.payload;
    end
    if (s1_fire) begin
      s2_rsp_q <= store_rsp;
    end
  end

  lruc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_fire_i  (s1_fire),
    .req_i       (s1_req_q),
    .rsp_o       (store_rsp),
    .valid_o     (entry_valid),
    .count_o     (entry_count)
  );

  assign get_fire    = s1_fire && (s1_req_q.command == lruc_pkg::CMD_GET);
  assign entry_state = {entry_valid, entry_count};

  // The fill count must track the valid bits and never pass the entry count.
  `LRUC_ASSERT(a_count_bound, clk_i, rst_ni, entry_count <= CntW'(ENTRIES))
  `LRUC_ASSERT(a_count_matches_valid, clk_i, rst_ni, $countones(entry_valid) == entry_count)
  `LRUC_ASSERT_NEXT(a_get_keeps_count, clk_i, rst_ni, get_fire, $stable(entry_state))

endmodule

@@ hdl/lruc_store.sv @@
// ----------------------------------------------------------------------------
// LRU cache entry store
// Fully associative key/value entries with recency ranks, the capacity
// register, and the combinational lookup and registered update of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lruc_store #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lruc_pkg::CAP_W-1:0]          cfg_wdata_i,
  input  logic                                req_fire_i,
  input  lruc_pkg::req_t                      req_i,
  output lruc_pkg::rsp_t                      rsp_o,
  output logic [ENTRIES-1:0]                  valid_o,
  output logic [$clog2(ENTRIES + 1)-1:0]      count_o
);

  localparam int unsigned RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW  = (CntW > lruc_pkg::CAP_W) ? CntW : lruc_pkg::CAP_W;

  logic [lruc_pkg::KEY_W-1:0]   key_q [ENTRIES];
  logic [lruc_pkg::VALUE_W-1:0] val_q [ENTRIES];
  logic [RankW-1:0]             rank_q [ENTRIES];
  logic [RankW-1:0]             rank_t [ENTRIES];
  logic [RankW-1:0]             rank_d [ENTRIES];
  logic [ENTRIES-1:0]           vld_q, vld_t, vld_d;
  logic [ENTRIES-1:0]           wr_key, wr_val;
  logic [CntW-1:0]              count_q, count_d, cnt_t;
  logic [lruc_pkg::CAP_W-1:0]   cap_q;

  logic [ENTRIES-1:0]           match;
  logic [ENTRIES-1:0]           free_oh;
  logic [RankW-1:0]             hit_rank;
  logic [RankW-1:0]             last_rank;
  logic [RankW-1:0]             evict_rank;
  logic [lruc_pkg::VALUE_W-1:0] hit_value;
  logic                         hit, is_put, full, ins_new, over_cap;
  logic [CmpW-1:0]              cap_eff;

  always_comb begin
    match     = '0;
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = vld_q[i] && (key_q[i] == req_i.key);
      if (match[i]) begin
        hit_rank  = hit_rank | rank_q[i];
        hit_value = hit_value | val_q[i];
      end
    end
    hit     = |match;
    is_put  = (req_i.command == lruc_pkg::CMD_PUT);
    full    = (count_q == CntW'(ENTRIES));
    // Valid ranks are always 0..count-1, so the oldest entry holds count-1.
    last_rank = RankW'(count_q - CntW'(1));
    // Lowest clear bit of the valid vector is the first free slot.
    free_oh = ~vld_q & (vld_q + ENTRIES'(1));
    ins_new = is_put && !hit && !full;
    cnt_t   = count_q + CntW'(ins_new);

    for (int i = 0; i < ENTRIES; i++) begin
      vld_t[i]  = vld_q[i];
      rank_t[i] = rank_q[i];
      wr_key[i] = 1'b0;
      wr_val[i] = 1'b0;
      if (hit) begin
        if (match[i]) begin
          rank_t[i] = '0;
          wr_val[i] = is_put;
        end else if (vld_q[i] && (rank_q[i] < hit_rank)) begin
          rank_t[i] = rank_q[i] + RankW'(1);
        end
      end else if (is_put) begin
        if (full ? (rank_q[i] == last_rank) : free_oh[i]) begin
          vld_t[i]  = 1'b1;
          rank_t[i] = '0;
          wr_key[i] = 1'b1;
          wr_val[i] = 1'b1;
        end else if (vld_q[i]) begin
          rank_t[i] = rank_q[i] + RankW'(1);
        end
      end
    end

    cap_eff = (CmpW'(cap_q) > CmpW'(ENTRIES)) ? CmpW'(ENTRIES) : CmpW'(cap_q);
    // Reusing the oldest slot of a full store already counts as the eviction.
    over_cap   = is_put && !(!hit && full) && (CmpW'(cnt_t) > cap_eff);
    evict_rank = RankW'(cnt_t - CntW'(1));

    for (int i = 0; i < ENTRIES; i++) begin
      vld_d[i]  = vld_t[i];
      rank_d[i] = rank_t[i];
      if (over_cap && vld_t[i] && (rank_t[i] == evict_rank)) begin
        vld_d[i]  = 1'b0;
        rank_d[i] = '0;
      end
    end
    count_d = cnt_t - CntW'(over_cap);

    rsp_o.hit = hit;
    if (is_put) begin
      rsp_o.read_value = lruc_pkg::PUT_VALUE;
    end else if (hit) begin
      rsp_o.read_value = hit_value;
    end else begin
      rsp_o.read_value = lruc_pkg::MISS_VALUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (req_fire_i) begin
      vld_q   <= vld_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire_i) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (wr_key[i]) begin
          key_q[i] <= req_i.key;
        end
        if (wr_val[i]) begin
          val_q[i] <= req_i.value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lruc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign valid_o = vld_q;
  assign count_o = count_q;

endmodule
